// ----- sv/vsr_pkg.sv -----
// shared types and constants for the vector scale and renormalise pipeline
package vsr_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_Z = 2'd2;

    // sideband that travels with every vector down the pipe
    typedef struct packed {
        logic       valid;
        logic       norm;
        logic [2:0] neg;
    } vsr_tag_t;

endpackage

// ----- sv/vsr_scale_lane.sv -----
// one axis: magnitude multiply, then floor and saturate back to fixed point
module vsr_scale_lane #(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [COMP_WIDTH-1:0] comp,
    input  logic [COMP_WIDTH-1:0] scale,
    output logic [COMP_WIDTH-1:0] mag,
    output logic                  neg
);
    localparam int CW = COMP_WIDTH;
    // wide enough for the shifted product and for the saturation limit
    localparam int QW = (CW + 1 > 2 * CW - FRAC_BITS + 1) ? CW + 1 : 2 * CW - FRAC_BITS + 1;

    logic [CW-1:0]   cm;
    logic [CW-1:0]   sm;
    logic [2*CW-1:0] prod_reg;
    logic            sign_reg;
    logic [QW-1:0]   q;
    logic [QW-1:0]   limit;
    logic [QW-1:0]   sat;
    logic [CW-1:0]   mag_reg;
    logic            neg_reg;

    assign cm = comp[CW-1]  ? (~comp + 1'b1)  : comp;
    assign sm = scale[CW-1] ? (~scale + 1'b1) : scale;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= cm * sm;
            sign_reg <= comp[CW-1] ^ scale[CW-1];
        end
    end

    // floor: a negative product with a fraction moves one step further out
    always_comb
    begin
        q = QW'(prod_reg[2*CW-1:FRAC_BITS])
            + QW'(sign_reg & (|prod_reg[FRAC_BITS-1:0]));
        limit = (QW'(1) << (CW - 1)) - QW'(!sign_reg);
        sat = (q > limit) ? limit : q;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= sat[CW-1:0];
            neg_reg <= sign_reg & (|sat);
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;
endmodule

// ----- sv/vsr_sqrt_cell.sv -----
// one result bit of the integer square root, restoring digit by digit
module vsr_sqrt_cell #(
    parameter int COMP_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  vsr_pkg::vsr_tag_t          tag_in,
    input  logic [2*COMP_WIDTH-1:0]    rad_in,
    input  logic [COMP_WIDTH+1:0]      rem_in,
    input  logic [COMP_WIDTH-1:0]      root_in,
    input  logic [2:0][COMP_WIDTH-1:0] m_in,
    output vsr_pkg::vsr_tag_t          tag_out,
    output logic [2*COMP_WIDTH-1:0]    rad_out,
    output logic [COMP_WIDTH+1:0]      rem_out,
    output logic [COMP_WIDTH-1:0]      root_out,
    output logic [2:0][COMP_WIDTH-1:0] m_out
);
    import vsr_pkg::*;
    localparam int CW = COMP_WIDTH;

    logic [CW+1:0]   r2;
    logic [CW+1:0]   trial;
    logic            ge;
    vsr_tag_t        tag_reg;
    logic [2*CW-1:0] rad_reg;
    logic [CW+1:0]   rem_reg;
    logic [CW-1:0]   root_reg;
    logic [2:0][CW-1:0] m_reg;

    always_comb
    begin
        r2    = {rem_in[CW-1:0], rad_in[2*CW-1:2*CW-2]};
        trial = {root_in, 2'b01};
        ge    = (r2 >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {rad_in[2*CW-3:0], 2'b00};
            rem_reg  <= ge ? (r2 - trial) : r2;
            root_reg <= {root_in[CW-2:0], ge};
            m_reg    <= m_in;
        end
    end

    assign tag_out  = tag_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign m_out    = m_reg;
endmodule

// ----- sv/vsr_div_cell.sv -----
// one quotient bit of the three divisions by the length, restoring
module vsr_div_cell #(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  vsr_pkg::vsr_tag_t          tag_in,
    input  logic [COMP_WIDTH-1:0]      len_in,
    input  logic [2:0][COMP_WIDTH-1:0] m_in,
    input  logic [2:0][COMP_WIDTH-1:0] rem_in,
    input  logic [2:0]                 feed_in,
    input  logic [2:0][FRAC_BITS:0]    q_in,
    output vsr_pkg::vsr_tag_t          tag_out,
    output logic [COMP_WIDTH-1:0]      len_out,
    output logic [2:0][COMP_WIDTH-1:0] m_out,
    output logic [2:0][COMP_WIDTH-1:0] rem_out,
    output logic [2:0]                 feed_out,
    output logic [2:0][FRAC_BITS:0]    q_out
);
    import vsr_pkg::*;
    localparam int CW = COMP_WIDTH;

    logic [2:0][CW:0]   r2;
    logic [2:0][CW:0]   diff;
    logic [2:0]         ge;
    vsr_tag_t           tag_reg;
    logic [CW-1:0]      len_reg;
    logic [2:0][CW-1:0] m_reg;
    logic [2:0][CW-1:0] rem_reg;
    logic [2:0][FRAC_BITS:0] q_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r2[i]   = {rem_in[i], feed_in[i]};
            diff[i] = r2[i] - {1'b0, len_in};
            ge[i]   = (r2[i] >= {1'b0, len_in});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg <= len_in;
            m_reg   <= m_in;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= ge[i] ? diff[i][CW-1:0] : r2[i][CW-1:0];
                q_reg[i]   <= {q_in[i][FRAC_BITS-1:0], ge[i]};
            end
        end
    end

    assign tag_out  = tag_reg;
    assign len_out  = len_reg;
    assign m_out    = m_reg;
    assign rem_out  = rem_reg;
    assign feed_out = 3'b000;
    assign q_out    = q_reg;
endmodule

// ----- sv/vsr_out_buf.sv -----
// two-entry output buffer so the pipe keeps moving while a result waits
module vsr_out_buf #(
    parameter int DATA_W = 96
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    output logic              tvalid,
    input  logic              tready,
    output logic [DATA_W-1:0] tdata
);
    logic              vld0_reg;
    logic              vld0_next;
    logic              vld1_reg;
    logic              vld1_next;
    logic [DATA_W-1:0] e0_reg;
    logic [DATA_W-1:0] e0_next;
    logic [DATA_W-1:0] e1_reg;
    logic [DATA_W-1:0] e1_next;
    logic              pop;

    assign pop = vld0_reg & tready;

    always_comb
    begin
        vld0_next = vld0_reg;
        vld1_next = vld1_reg;
        e0_next   = e0_reg;
        e1_next   = e1_reg;
        if (pop)
        begin
            e0_next   = vld1_reg ? e1_reg : push_data;
            vld0_next = vld1_reg | push;
            vld1_next = 1'b0;
        end
        else if (push)
        begin
            if (!vld0_reg)
            begin
                e0_next   = push_data;
                vld0_next = 1'b1;
            end
            else
            begin
                e1_next   = push_data;
                vld1_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= vld0_next;
            vld1_reg <= vld1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign full   = vld1_reg;
    assign tvalid = vld0_reg;
    assign tdata  = e0_reg;
endmodule

// ----- sv/vector_scale_renormalize.sv -----
// per-axis scaling of a vector with renormalisation of normals
// path from input transaction to output valid: 4 front stages, COMP_WIDTH root cells,
// FRAC_BITS + 1 divide cells, then the output buffer
// throughput: one vector per cycle; the root and the divisions run as a chain of one-bit cells
// the input stalls only while the two-entry output buffer is full
// rst_n clears all valid bits and sets the three scale registers to 1.0
module vector_scale_renormalize #(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [vsr_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [COMP_WIDTH-1:0]                   cfg_data,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((3*COMP_WIDTH+7)/8)*8-1:0]       s_axis_tdata,  // in_x, in_y, in_z, zero pad
    input  logic                                    s_axis_tuser,  // kind
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((3*COMP_WIDTH+7)/8)*8-1:0]       m_axis_tdata   // out_x, out_y, out_z, zero pad
);
    import vsr_pkg::*;
    localparam int CW = COMP_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int MW = (CW > FB + 1) ? CW : FB + 1;
    localparam int DATA_W = ((3 * COMP_WIDTH + 7) / 8) * 8;

    logic [2:0][CW-1:0] scale_reg;
    logic               en;
    logic               full;
    logic [2:0][CW-1:0] lane_m;
    logic [2:0]         lane_neg;
    vsr_tag_t           tag1_reg;
    vsr_tag_t           tag2_reg;
    vsr_tag_t           tag3_reg;
    vsr_tag_t           tag4_reg;
    logic [2:0][CW-1:0]   m3_reg;
    logic [2:0][2*CW-1:0] sq_reg;
    logic [2:0][CW-1:0]   m4_reg;
    logic [2*CW-1:0]      sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= {3{CW'(1) << FB}};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCALE_X: scale_reg[0] <= cfg_data;
                REG_SCALE_Y: scale_reg[1] <= cfg_data;
                REG_SCALE_Z: scale_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en            = !full;
    assign s_axis_tready = en;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        vsr_scale_lane #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) u_lane (
            .clk   (clk),
            .en    (en),
            .comp  (s_axis_tdata[i*CW +: CW]),
            .scale (scale_reg[i]),
            .mag   (lane_m[i]),
            .neg   (lane_neg[i])
        );
    end

    // norm holds the kind bit until the scaled magnitudes are known
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= '{valid: s_axis_tvalid, norm: s_axis_tuser, neg: 3'b000};
            tag2_reg <= tag1_reg;
            tag3_reg <= '{valid: tag2_reg.valid,
                          norm:  tag2_reg.norm & (|lane_m),
                          neg:   lane_neg};
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_reg <= lane_m;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= lane_m[i] * lane_m[i];
            end
            m4_reg  <= m3_reg;
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    // square root chain
    vsr_tag_t           sq_tag  [CW+1];
    logic [2*CW-1:0]    sq_rad  [CW+1];
    logic [CW+1:0]      sq_rem  [CW+1];
    logic [CW-1:0]      sq_root [CW+1];
    logic [2:0][CW-1:0] sq_m    [CW+1];

    assign sq_tag[0]  = tag4_reg;
    assign sq_rad[0]  = sum_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_m[0]    = m4_reg;

    for (genvar k = 0; k < CW; k++)
    begin : g_sqrt
        vsr_sqrt_cell #(.COMP_WIDTH(CW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .tag_in   (sq_tag[k]),
            .rad_in   (sq_rad[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .m_in     (sq_m[k]),
            .tag_out  (sq_tag[k+1]),
            .rad_out  (sq_rad[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1]),
            .m_out    (sq_m[k+1])
        );
    end

    // division chain: quotient never exceeds 2^FB, so only FB+1 bits are formed
    vsr_tag_t              dv_tag  [FB+2];
    logic [CW-1:0]         dv_len  [FB+2];
    logic [2:0][CW-1:0]    dv_m    [FB+2];
    logic [2:0][CW-1:0]    dv_rem  [FB+2];
    logic [2:0]            dv_feed [FB+2];
    logic [2:0][FB:0]      dv_q    [FB+2];

    assign dv_tag[0] = sq_tag[CW];
    assign dv_len[0] = sq_root[CW];
    assign dv_m[0]   = sq_m[CW];
    assign dv_q[0]   = '0;
    for (genvar i = 0; i < 3; i++)
    begin : g_div_init
        assign dv_rem[0][i]  = sq_m[CW][i] >> 1;
        assign dv_feed[0][i] = sq_m[CW][i][0];
    end

    for (genvar j = 0; j <= FB; j++)
    begin : g_div
        vsr_div_cell #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .tag_in   (dv_tag[j]),
            .len_in   (dv_len[j]),
            .m_in     (dv_m[j]),
            .rem_in   (dv_rem[j]),
            .feed_in  (dv_feed[j]),
            .q_in     (dv_q[j]),
            .tag_out  (dv_tag[j+1]),
            .len_out  (dv_len[j+1]),
            .m_out    (dv_m[j+1]),
            .rem_out  (dv_rem[j+1]),
            .feed_out (dv_feed[j+1]),
            .q_out    (dv_q[j+1])
        );
    end

    // pick normalised or scaled magnitude, saturate and apply sign
    vsr_tag_t        fin_tag;
    logic [DATA_W-1:0] packed_out;
    logic [MW-1:0]   fmag  [3];
    logic [MW-1:0]   flim  [3];
    logic [MW-1:0]   fsat  [3];

    assign fin_tag = dv_tag[FB+1];

    always_comb
    begin
        packed_out = '0;
        for (int i = 0; i < 3; i++)
        begin
            fmag[i] = fin_tag.norm ? MW'(dv_q[FB+1][i]) : MW'(dv_m[FB+1][i]);
            flim[i] = (MW'(1) << (CW - 1)) - MW'(!fin_tag.neg[i]);
            fsat[i] = (fmag[i] > flim[i]) ? flim[i] : fmag[i];
            packed_out[i*CW +: CW] = fin_tag.neg[i] ? (~fsat[i][CW-1:0] + 1'b1)
                                                    : fsat[i][CW-1:0];
        end
    end

    vsr_out_buf #(.DATA_W(DATA_W)) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fin_tag.valid & en),
        .push_data (packed_out),
        .full      (full),
        .tvalid    (m_axis_tvalid),
        .tready    (m_axis_tready),
        .tdata     (m_axis_tdata)
    );
endmodule

// ----- sv/vsr_checker.sv -----
// port-level checks for the vector scale and renormalise block
module vsr_checker #(
    parameter int DATA_W = 96
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped before transaction");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // input only stalls when the buffer holds results
    a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // buffer can only fill while the output is being held off
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");
endmodule

bind vector_scale_renormalize vsr_checker #(.DATA_W(DATA_W)) u_vsr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
